// ===== rtl/core/acae_pkg.sv =====
`timescale 1ns / 1ps
package acae_pkg;

  localparam int FRAC_BITS    = 15;
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 24;
  localparam int W_TRIG       = 33;  // Q30 sine/cosine with headroom
  localparam int W_Z          = 33;  // residual angle, turn/2^32 units
  localparam int W_P          = 35;  // 2*rb*rd*kb*kd, Q30
  localparam int W_SQ         = 33;  // rb^2 + rd^2, Q30
  localparam int W_TP         = 18;  // trig product, Q16
  localparam int W_ND         = 54;  // numerator / denominator
  localparam logic signed [W_TRIG-1:0] CORDIC_GAIN = 33'sd652032874;

  localparam logic [30:0] ATAN_TURN [CORDIC_STEPS] = '{
    31'd536870912, 31'd316933406, 31'd167458907, 31'd85004756, 31'd42667331,
    31'd21354465, 31'd10679838, 31'd5340245, 31'd2670163, 31'd1335087,
    31'd667544, 31'd333772, 31'd166886, 31'd83443, 31'd41722, 31'd20861,
    31'd10430, 31'd5215, 31'd2608, 31'd1304, 31'd652, 31'd326, 31'd163, 31'd81
  };

  typedef struct packed {
    logic [15:0] ratio_b;
    logic [15:0] phase_b;
    logic [15:0] coherence_b;
    logic [15:0] ratio_d;
    logic [15:0] phase_d;
    logic [15:0] coherence_d;
    logic [15:0] weak_phase;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] asymmetry;
    logic               zero_denominator;
  } out_beat_t;

  // entry of the queue between front and back
  typedef struct packed {
    logic [ANGLE_BITS-1:0] phase_sum;
    logic [ANGLE_BITS-1:0] weak_phase;
    logic [15:0]           coherence_b;
    logic [15:0]           coherence_d;
    logic [31:0]           ratio_prod;
    logic [W_SQ-1:0]       ratio_sq;
  } work_t;

endpackage

// ===== rtl/core/acae_front.sv =====
`timescale 1ns / 1ps
module acae_front import acae_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_beat_t in_data_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output work_t    q_data_o
);

  logic  valid_q;
  work_t work_q, work_d;
  logic [31:0] sq_b, sq_d;

  always_comb begin
    sq_b = {16'b0, in_data_i.ratio_b} * {16'b0, in_data_i.ratio_b};
    sq_d = {16'b0, in_data_i.ratio_d} * {16'b0, in_data_i.ratio_d};
    work_d.phase_sum   = in_data_i.phase_b[ANGLE_BITS-1:0]
                       + in_data_i.phase_d[ANGLE_BITS-1:0];
    work_d.weak_phase  = in_data_i.weak_phase[ANGLE_BITS-1:0];
    work_d.coherence_b = in_data_i.coherence_b;
    work_d.coherence_d = in_data_i.coherence_d;
    work_d.ratio_prod  = {16'b0, in_data_i.ratio_b} * {16'b0, in_data_i.ratio_d};
    work_d.ratio_sq    = {1'b0, sq_b} + {1'b0, sq_d};
  end

  assign in_stall_o = valid_q && q_full_i;
  assign q_push_o   = valid_q && !q_full_i;
  assign q_data_o   = work_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      work_q <= work_d;
    end
  end

endmodule

// ===== rtl/core/acae_fifo.sv =====
`timescale 1ns / 1ps
module acae_fifo import acae_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  work_t data_i,
  input  logic  pop_i,
  output work_t data_o,
  output logic  full_o,
  output logic  empty_o
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  work_t         mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/core/acae_cordic.sv =====
`timescale 1ns / 1ps
module acae_cordic import acae_pkg::*; (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic [ANGLE_BITS-1:0]    angle_i,
  output logic signed [W_TRIG-1:0] sin_o,
  output logic signed [W_TRIG-1:0] cos_o
);

  logic signed [W_TRIG-1:0] x_q [CORDIC_STEPS+1];
  logic signed [W_TRIG-1:0] y_q [CORDIC_STEPS+1];
  logic signed [W_Z-1:0]    z_q [CORDIC_STEPS+1];
  logic                     flip_q [CORDIC_STEPS+1];
  logic [31:0] ang, ang_r;
  logic        flip;

  // fold the left half plane onto the right by a half turn
  always_comb begin
    ang   = {angle_i, (32 - ANGLE_BITS)'(0)};
    flip  = ang[31] ^ ang[30];
    ang_r = {ang[31] ^ flip, ang[30:0]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= CORDIC_GAIN;
      y_q[0]    <= '0;
      z_q[0]    <= {ang_r[31], ang_r};
      flip_q[0] <= flip;
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        flip_q[i+1] <= flip_q[i];
        if (!z_q[i][W_Z-1]) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - $signed({2'b0, ATAN_TURN[i]});
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + $signed({2'b0, ATAN_TURN[i]});
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sin_o <= flip_q[CORDIC_STEPS] ? -y_q[CORDIC_STEPS] : y_q[CORDIC_STEPS];
      cos_o <= flip_q[CORDIC_STEPS] ? -x_q[CORDIC_STEPS] : x_q[CORDIC_STEPS];
    end
  end

endmodule

// ===== rtl/core/acae_back.sv =====
`timescale 1ns / 1ps
module acae_back import acae_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_empty_i,
  input  work_t     q_data_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  localparam int LAT = CORDIC_STEPS + FRAC_BITS + 6;

  logic [LAT-1:0] vld_q;
  logic           adv;

  assign adv     = !vld_q[LAT-1] || !out_stall_i;
  assign q_pop_o = adv && !q_empty_i;
  assign out_valid_o = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], q_pop_o};
    end
  end

  // trig units
  logic signed [W_TRIG-1:0] ss, cs, sg, cg;

  acae_cordic u_cordic_sum (
    .clk_i  (clk_i),
    .en_i   (adv),
    .angle_i(q_data_i.phase_sum),
    .sin_o  (ss),
    .cos_o  (cs)
  );

  acae_cordic u_cordic_weak (
    .clk_i  (clk_i),
    .en_i   (adv),
    .angle_i(q_data_i.weak_phase),
    .sin_o  (sg),
    .cos_o  (cg)
  );

  // magnitude product, then delay to line up with the trig units
  logic [47:0]        m1;
  logic [48:0]        m2;
  logic [47-FRAC_BITS:0] p2_q;
  logic [15:0]        kd_q;
  logic [W_SQ-1:0]    sq1_q, sq2_q;
  logic [W_P-1:0]     p_q;
  logic [W_P-1:0]     dp_q  [CORDIC_STEPS];
  logic [W_SQ-1:0]    dsq_q [CORDIC_STEPS];

  assign m1 = {16'b0, q_data_i.ratio_prod} * {32'b0, q_data_i.coherence_b};
  assign m2 = 49'(p2_q) * {33'b0, kd_q};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p2_q     <= m1[47:FRAC_BITS];
      kd_q     <= q_data_i.coherence_d;
      sq1_q    <= q_data_i.ratio_sq;
      p_q      <= W_P'({m2[48:FRAC_BITS], 1'b0});
      sq2_q    <= sq1_q;
      dp_q[0]  <= p_q;
      dsq_q[0] <= sq2_q;
      for (int i = 1; i < CORDIC_STEPS; i++) begin
        dp_q[i]  <= dp_q[i-1];
        dsq_q[i] <= dsq_q[i-1];
      end
    end
  end

  // trig products rounded to Q16
  logic signed [2*W_TRIG-1:0] mn, md;
  logic signed [W_TP-1:0]     tn_q, td_q;
  logic [W_P-1:0]             p3_q;
  logic [W_SQ-1:0]            sq3_q, sq4_q;
  logic signed [W_ND-1:0]     n_q, pd_q;

  always_comb begin
    mn = ss * sg + (66'sd1 <<< 43);
    md = cs * cg + (66'sd1 <<< 43);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      tn_q  <= mn[44+W_TP-1:44];
      td_q  <= md[44+W_TP-1:44];
      p3_q  <= dp_q[CORDIC_STEPS-1];
      sq3_q <= dsq_q[CORDIC_STEPS-1];
      n_q   <= $signed({1'b0, p3_q}) * tn_q;
      pd_q  <= $signed({1'b0, p3_q}) * td_q;
      sq4_q <= sq3_q;
    end
  end

  // sign, magnitude and saturation check
  logic signed [W_ND-1:0] d;
  logic [W_ND-1:0]        num, den;

  always_comb begin
    d   = $signed({{(W_ND-W_SQ-16){1'b0}}, sq4_q, 16'b0}) + pd_q;
    num = n_q[W_ND-1] ? W_ND'(-n_q) : W_ND'(n_q);
    den = d[W_ND-1] ? W_ND'(-d) : W_ND'(d);
  end

  // restoring divider, one quotient bit per stage
  logic [W_ND-1:0]      r_q   [FRAC_BITS+1];
  logic [W_ND-1:0]      den_q [FRAC_BITS+1];
  logic [FRAC_BITS-1:0] qv_q  [FRAC_BITS+1];
  logic                 neg_q [FRAC_BITS+1];
  logic                 zero_q[FRAC_BITS+1];
  logic                 sat_q [FRAC_BITS+1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_q[0]    <= num;
      den_q[0]  <= den;
      qv_q[0]   <= '0;
      neg_q[0]  <= n_q[W_ND-1] ^ d[W_ND-1];
      zero_q[0] <= (d == '0);
      sat_q[0]  <= (num >= den);
    end
  end

  for (genvar j = 0; j < FRAC_BITS; j++) begin : g_div
    logic [W_ND-1:0] r2;
    logic            ge;
    assign r2 = {r_q[j][W_ND-2:0], 1'b0};
    assign ge = (r2 >= den_q[j]);
    always_ff @(posedge clk_i) begin
      if (adv) begin
        r_q[j+1]    <= ge ? r2 - den_q[j] : r2;
        qv_q[j+1]   <= {qv_q[j][FRAC_BITS-2:0], ge};
        den_q[j+1]  <= den_q[j];
        neg_q[j+1]  <= neg_q[j];
        zero_q[j+1] <= zero_q[j];
        sat_q[j+1]  <= sat_q[j];
      end
    end
  end

  // round half up on magnitude, apply sign, saturate
  logic [W_ND-1:0]    rf;
  logic [FRAC_BITS:0] qf;
  out_beat_t          res_d, res_q;

  always_comb begin
    rf = {r_q[FRAC_BITS][W_ND-2:0], 1'b0};
    qf = {1'b0, qv_q[FRAC_BITS]} + (FRAC_BITS+1)'(rf >= den_q[FRAC_BITS]);
    res_d.zero_denominator = 1'b0;
    if (zero_q[FRAC_BITS]) begin
      res_d.asymmetry        = '0;
      res_d.zero_denominator = 1'b1;
    end else if (sat_q[FRAC_BITS]) begin
      res_d.asymmetry = neg_q[FRAC_BITS] ? 16'sh8000 : 16'sh7fff;
    end else if (neg_q[FRAC_BITS]) begin
      res_d.asymmetry = 16'(-qf);
    end else if (qf[FRAC_BITS]) begin
      res_d.asymmetry = 16'sh7fff;
    end else begin
      res_d.asymmetry = 16'(qf);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_data_o = res_q;

endmodule

// ===== rtl/core/ads_cp_asymmetry_eval.sv =====
`timescale 1ns / 1ps
// ads cp asymmetry evaluator: each input beat carries two ratios, two coherences,
// two strong phases and a weak phase; each output beat returns
// A = 2 rb rd kb kd sin(db+dd) sin(g) / (rb^2 + rd^2 + 2 rb rd kb kd cos(db+dd) cos(g))
// as signed q1.15, saturated, with zero_denominator set (and A = 0) when the
// denominator is exactly zero. one beat is accepted per cycle and results leave
// in order, one per cycle, while nothing stalls. an accepted beat passes the
// front register, the two-entry queue and a 45-stage back pipeline whose first
// stage loads at the pop edge: 26 for the two pipelined cordic units, 3 for
// products and sign, 15 divider stages for the quotient bits, 1 for rounding
// and saturation. the front stalls only when the queue is full; the back holds
// when the output beat is stalled.
module ads_cp_asymmetry_eval import acae_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o
);

  // queue between front and back
  logic  q_push, q_pop, q_full, q_empty;
  work_t q_wdata, q_rdata;

  acae_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_data_i (in_data_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_data_o  (q_wdata)
  );

  acae_fifo #(
    .DEPTH(2)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  acae_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_data_i   (q_rdata),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // a zero denominator always yields a zero asymmetry
  a_zero_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.zero_denominator) |-> (out_data_o.asymmetry == '0))
    else $error("zero denominator with nonzero asymmetry");

  // the queue never takes a beat while full nor gives one while empty
  a_queue_bounds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_push && q_full && !q_pop) && !(q_pop && q_empty))
    else $error("queue overflow or underflow");

  // the input is stalled only while the front holds a beat the queue cannot take
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (q_full && !q_push))
    else $error("input stalled without a full queue");

endmodule

// ===== bench/ads_cp_asymmetry_eval_check.sv =====
`timescale 1ns / 1ps
module ads_cp_asymmetry_eval_check import acae_pkg::*; (
  input  logic      clk_i,
  input  logic      in_valid_i,
  input  logic      in_stall_i,
  input  in_beat_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_stall_i,
  input  out_beat_t out_data_i,
  output int        fail_count_o,
  output int        pending_o
);

  out_beat_t asym_expected_q[$];

  localparam longint ATAN_TAB [24] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };

  // rotation-mode sine/cosine, q30, angle in 16-bit turn fraction
  function automatic void rotate_angle(input logic [15:0] ang, output longint s,
                                       output longint c);
    logic [31:0] a;
    logic flip;
    longint x, y, z, t;
    a = {ang, 16'h0};
    flip = 1'b0;
    x = 652032874;
    y = 0;
    if (a >= 32'h4000_0000 && a < 32'hC000_0000) begin
      flip = 1'b1;
      a = a - 32'h8000_0000;
    end
    z = longint'(a);
    if (a >= 32'h8000_0000) z = z - 64'sh1_0000_0000;
    for (int i = 0; i < 24; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z = z - ATAN_TAB[i];
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z = z + ATAN_TAB[i];
      end
      x = t;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = y;
    c = x;
  endfunction

  function automatic out_beat_t predict_asymmetry(in_beat_t b);
    longint ss, cs, sg, cg, tn, td, n, d, val;
    logic [63:0] p, num, den, r, q, rb, rd;
    logic neg;
    out_beat_t o;
    rotate_angle(b.phase_b + b.phase_d, ss, cs);
    rotate_angle(b.weak_phase, sg, cg);
    tn = (ss * sg + (64'sd1 <<< 43)) >>> 44;
    td = (cs * cg + (64'sd1 <<< 43)) >>> 44;
    rb = b.ratio_b;
    rd = b.ratio_d;
    p = rb * rd;
    p = (p * b.coherence_b) >> 15;
    p = (p * b.coherence_d) >> 15;
    p = p * 2;
    n = longint'(p) * tn;
    d = longint'((rb * rb + rd * rd) << 16) + longint'(p) * td;
    o = '0;
    if (d == 0) begin
      o.zero_denominator = 1'b1;
      return o;
    end
    neg = (n < 0) != (d < 0);
    num = n < 0 ? -n : n;
    den = d < 0 ? -d : d;
    if (num >= den) begin
      val = neg ? -32768 : 32767;
    end else begin
      r = num;
      q = 0;
      for (int i = 0; i < 15; i++) begin
        r = r << 1;
        q = q << 1;
        if (r >= den) begin
          r = r - den;
          q = q | 1;
        end
      end
      r = r << 1;
      if (r >= den) q = q + 1;
      val = neg ? -longint'(q) : longint'(q);
      if (val > 32767) val = 32767;
      if (val < -32768) val = -32768;
    end
    o.asymmetry = val[15:0];
    return o;
  endfunction

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i) begin
    out_beat_t e;
    if (in_valid_i && !in_stall_i) asym_expected_q.push_back(predict_asymmetry(in_data_i));
    if (out_valid_i && !out_stall_i) begin
      if (asym_expected_q.size() == 0) begin
        $display("%0t: unexpected beat, actual %h", $time, out_data_i);
        fail_count_o <= fail_count_o + 1;
      end else begin
        e = asym_expected_q.pop_front();
        if (e.asymmetry !== out_data_i.asymmetry ||
            e.zero_denominator !== out_data_i.zero_denominator) begin
          $display("%0t: mismatch, expected a=%0d z=%b, actual a=%0d z=%b", $time,
                   e.asymmetry, e.zero_denominator, out_data_i.asymmetry,
                   out_data_i.zero_denominator);
          fail_count_o <= fail_count_o + 1;
        end
      end
    end
    pending_o <= asym_expected_q.size();
  end

endmodule

// ===== bench/ads_cp_asymmetry_eval_test.sv =====
`timescale 1ns / 1ps
module ads_cp_asymmetry_eval_test;
  import acae_pkg::*;

  logic      clk, rst_n;
  logic      in_valid, in_stall, out_valid, out_stall;
  in_beat_t  in_data;
  out_beat_t out_data;
  int        fail_count, pending;
  int        idle_cycles;
  bit        stim_done;

  ads_cp_asymmetry_eval dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  ads_cp_asymmetry_eval_check checker_i (
    .clk_i(clk), .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // gap length: mostly zero or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // coherence within 0..32768, extremes favored
  function automatic logic [15:0] rand_coh();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'd32768;
      2: return 16'd32767;
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  function automatic logic [15:0] rand_ratio();
    case ($urandom_range(0, 7))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 255));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(0, 7))
      0: return 16'h0000 + 16'($urandom_range(0, 3)) << 14;
      1: return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // send one beat, holding it until taken; gap first, valid stays high
  // between back to back beats
  task automatic send_beat(input in_beat_t b);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_data  <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic send_fields(input logic [15:0] rb, pb, kb, rd, pd, kd, g);
    in_beat_t b;
    b = '{rb, pb, kb, rd, pd, kd, g};
    send_beat(b);
  endtask

  // receiver stalls in bursts, with calm stretches
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(0, 99) < 90 ? $urandom_range(1, 4) : $urandom_range(10, 50);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        repeat ($urandom_range(0, 30)) @(negedge clk);
      end
    end
  end

  // watchdog: cycles with nothing accepted on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    in_beat_t b;
    idle_cycles = 0;
    stim_done = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: zero denominator, full scale, phase wrap, quadrant angles
    send_fields(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_fields(16'd0, 16'h1234, 16'd32768, 16'd0, 16'h4321, 16'd32768, 16'h4000);
    send_fields(16'hFFFF, 16'hFFFF, 16'd32768, 16'hFFFF, 16'hFFFF, 16'd32768, 16'hFFFF);
    send_fields(16'd32768, 16'h4000, 16'd32768, 16'd32768, 16'd0, 16'd32768, 16'h4000);
    send_fields(16'd32768, 16'hC000, 16'd32768, 16'd32768, 16'd0, 16'd32768, 16'h4000);
    send_fields(16'd32768, 16'h8000, 16'd32768, 16'd32768, 16'd0, 16'd32768, 16'd0);
    send_fields(16'd32768, 16'h8000, 16'd32768, 16'd32768, 16'h0000, 16'd32768, 16'h8000);
    send_fields(16'd32768, 16'hF000, 16'd32768, 16'd32768, 16'h2000, 16'd32768, 16'h4000);
    send_fields(16'd100, 16'h2000, 16'd32768, 16'd200, 16'h1000, 16'd0, 16'h3000);
    send_fields(16'd1, 16'h4000, 16'd32768, 16'd1, 16'h0, 16'd32768, 16'hC000);
    send_fields(16'd32768, 16'h7FFF, 16'd32767, 16'd16384, 16'h8001, 16'd32767, 16'h5555);
    send_fields(16'hFFFF, 16'h2000, 16'd32768, 16'd1, 16'h2000, 16'd32768, 16'h4000);
    send_fields(16'h5555, 16'hAAAA, 16'd16384, 16'hAAAA, 16'h5555, 16'd16384, 16'hAAAA);
    send_fields(16'd32768, 16'h8000, 16'd32768, 16'd32768, 16'h0, 16'd32768, 16'hFFFF);

    // random
    for (int i = 0; i < 1500; i++) begin
      b.ratio_b     = rand_ratio();
      b.phase_b     = rand_angle();
      b.coherence_b = rand_coh();
      b.ratio_d     = $urandom_range(0, 3) == 0 ? b.ratio_b : rand_ratio();
      b.phase_d     = rand_angle();
      b.coherence_d = rand_coh();
      b.weak_phase  = rand_angle();
      send_beat(b);
    end
    in_valid <= 1'b0;

    stim_done = 1'b1;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/acae_pkg.sv
rtl/core/acae_front.sv
rtl/core/acae_fifo.sv
rtl/core/acae_cordic.sv
rtl/core/acae_back.sv
rtl/core/ads_cp_asymmetry_eval.sv
bench/ads_cp_asymmetry_eval_check.sv
bench/ads_cp_asymmetry_eval_test.sv
